### rtl/mask_boundary_edge_extractor_unit_defines.svh
// ----------------------------------------------------------------------------
// Mask boundary edge extractor: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MASK_BOUNDARY_EDGE_EXTRACTOR_UNIT_DEFINES_SVH
`define MASK_BOUNDARY_EDGE_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define MBEE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define MBEE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mbee_pkg.sv
// ----------------------------------------------------------------------------
// Mask boundary edge extractor: package
// Field widths, reset values, register indexes and result codes.
// ----------------------------------------------------------------------------
package mbee_pkg;

    localparam int COORD_W    = 13;
    localparam int SIZE_W     = 13;
    localparam int THR_W      = 8;
    localparam int BUDGET_W   = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int STATUS_W   = 2;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
    localparam logic [THR_W-1:0]    RST_FG_THRESHOLD = 8'd128;
    localparam logic [BUDGET_W-1:0] RST_EDGE_BUDGET  = 24'hFFFFFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_FG_THRESHOLD = 2'd2,
        CFG_EDGE_BUDGET  = 2'd3
    } t_cfg_idx;

    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FG  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BUDGET = 2'd2;

    // Result slots of one pixel, in emission order.
    localparam int SLOT_TOP    = 0;
    localparam int SLOT_LEFT   = 1;
    localparam int SLOT_RIGHT  = 2;
    localparam int SLOT_BOTTOM = 3;
    localparam int SLOT_DONE   = 4;
    localparam int NUM_EDGES   = 4;
    localparam int NUM_SLOTS   = 5;

    typedef struct packed {
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic                fg;
        logic [STATUS_W-1:0] status;
    } t_emit_ctx;

endpackage

### rtl/mask_boundary_edge_extractor_unit.sv
// ----------------------------------------------------------------------------
// Mask boundary edge extractor
// Turns a raster stream of coverage bytes into the directed crack edges
// between foreground and background, followed by a frame-done status item.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on i_valid/o_ready with i_coverage; results leave on
// o_valid/i_ready, one transaction per result, o_last marking the final
// result of a pixel. Registers are written through i_cfg_we, i_cfg_addr and
// i_cfg_data while the block is idle.
// A pixel is accepted into the read stage together with its column flag from
// the row memory, moves on to the emitter, and its results are registered in
// the output register. The single output register drains one result per
// cycle while the receiver keeps it free; a pixel holds the emitter until its
// last result (no more than an edge per side and the frame-done item) has left it.
// The row flag memory has one write port and one read port; a write and a
// read of the same column in the same cycle are forwarded.
// Reset restores the register defaults and empties the pipeline; the row
// memory is not cleared, as the first row of each frame never reads it.
// When the receiver holds i_ready low, the output register keeps its result,
// one pixel waits in the emitter and one in the read stage, and o_ready
// drops once both are full.
// ----------------------------------------------------------------------------
module mask_boundary_edge_extractor_unit #(
    parameter int MAX_WIDTH  = mbee_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mbee_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mbee_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [mbee_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [mbee_pkg::THR_W-1:0]      i_coverage,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_kind,
    output logic [mbee_pkg::COORD_W-1:0]    o_start_x,
    output logic [mbee_pkg::COORD_W-1:0]    o_start_y,
    output logic [mbee_pkg::COORD_W-1:0]    o_end_x,
    output logic [mbee_pkg::COORD_W-1:0]    o_end_y,
    output logic [mbee_pkg::STATUS_W-1:0]   o_frame_status,
    output logic                            o_last
);

`include "mask_boundary_edge_extractor_unit_defines.svh"

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WSW = (XW + 1 > mbee_pkg::SIZE_W) ? XW + 1 : mbee_pkg::SIZE_W;
    localparam int HSW = (YW + 1 > mbee_pkg::SIZE_W) ? YW + 1 : mbee_pkg::SIZE_W;
    localparam logic [WSW-1:0] W_MAX = WSW'(MAX_WIDTH);
    localparam logic [HSW-1:0] H_MAX = HSW'(MAX_HEIGHT);
    localparam int CW  = mbee_pkg::COORD_W;
    localparam int BW  = mbee_pkg::BUDGET_W;

    // Configuration registers
    logic [mbee_pkg::SIZE_W-1:0] r_frame_width;
    logic [mbee_pkg::SIZE_W-1:0] r_frame_height;
    logic [mbee_pkg::THR_W-1:0]  r_fg_threshold;
    logic [BW-1:0]               r_edge_budget;

    // Scan position
    logic [XW-1:0] r_col;
    logic [YW-1:0] r_row;
    logic          r_left;

    // Read stage
    logic          r_s1_vld;
    logic [XW-1:0] r_s1_x;
    logic [YW-1:0] r_s1_y;
    logic          r_s1_fg;
    logic          r_s1_left;
    logic          r_s1_top_row;
    logic          r_s1_row_end;
    logic          r_s1_bottom;
    logic          r_s1_frame_end;
    logic          r_s1_fwd;
    logic          r_s1_fwd_val;
    logic          r_rd;

    // Frame budget state
    logic [BW-1:0] r_edge_cnt;
    logic          r_budget_hit;

    // Emitter
    logic [mbee_pkg::NUM_SLOTS-1:0] r_pend;
    mbee_pkg::t_emit_ctx            r_ctx;

    // Output register
    logic                          r_out_vld;
    logic                          r_out_kind;
    logic [CW-1:0]                 r_out_sx;
    logic [CW-1:0]                 r_out_sy;
    logic [CW-1:0]                 r_out_ex;
    logic [CW-1:0]                 r_out_ey;
    logic [mbee_pkg::STATUS_W-1:0] r_out_status;
    logic                          r_out_last;

    logic r_flags [MAX_WIDTH];

    logic [WSW-1:0] w_eff;
    logic [HSW-1:0] h_eff;
    logic           in_acc;
    logic           pix_fg;
    logic           row_end;
    logic           bottom;
    logic           frame_end;
    logic           s1_adv;
    logic           s2_free;
    logic           emit;
    logic           out_free;

    logic                           above;
    logic [mbee_pkg::NUM_EDGES-1:0] cand;
    logic [mbee_pkg::NUM_EDGES-1:0] pass;
    logic [2:0]                     taken;
    logic [2:0]                     avail_cap;
    logic [BW:0]                    diff;
    logic                           hit_new;
    logic [BW-1:0]                  cnt_new;
    logic [mbee_pkg::STATUS_W-1:0]  status_new;

    logic [mbee_pkg::NUM_SLOTS-1:0] pend_low;
    logic [mbee_pkg::NUM_SLOTS-1:0] pend_rest;
    logic [CW-1:0]                  x0;
    logic [CW-1:0]                  x1;
    logic [CW-1:0]                  y0;
    logic [CW-1:0]                  y1;
    logic                           n_kind;
    logic [CW-1:0]                  n_sx;
    logic [CW-1:0]                  n_sy;
    logic [CW-1:0]                  n_ex;
    logic [CW-1:0]                  n_ey;
    logic [mbee_pkg::STATUS_W-1:0]  n_status;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mbee_pkg::RST_FRAME_WIDTH;
            r_frame_height <= mbee_pkg::RST_FRAME_HEIGHT;
            r_fg_threshold <= mbee_pkg::RST_FG_THRESHOLD;
            r_edge_budget  <= mbee_pkg::RST_EDGE_BUDGET;
        end else if (i_cfg_we) begin
            unique case (mbee_pkg::t_cfg_idx'(i_cfg_addr))
                mbee_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[mbee_pkg::SIZE_W-1:0];
                end
                mbee_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[mbee_pkg::SIZE_W-1:0];
                end
                mbee_pkg::CFG_FG_THRESHOLD: begin
                    r_fg_threshold <= i_cfg_data[mbee_pkg::THR_W-1:0];
                end
                mbee_pkg::CFG_EDGE_BUDGET: begin
                    r_edge_budget <= i_cfg_data[BW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A size of zero counts as one, and anything above the maximum as the maximum.
    always_comb begin
        if (WSW'(r_frame_width) == '0) begin
            w_eff = WSW'(1);
        end else if (WSW'(r_frame_width) > W_MAX) begin
            w_eff = W_MAX;
        end else begin
            w_eff = WSW'(r_frame_width);
        end
        if (HSW'(r_frame_height) == '0) begin
            h_eff = HSW'(1);
        end else if (HSW'(r_frame_height) > H_MAX) begin
            h_eff = H_MAX;
        end else begin
            h_eff = HSW'(r_frame_height);
        end
    end

    // ------------------------------------------------------------------
    // Pixel intake and scan position
    // ------------------------------------------------------------------
    assign o_ready   = !r_s1_vld || s1_adv;
    assign in_acc    = i_valid && o_ready;
    assign pix_fg    = i_coverage >= r_fg_threshold;
    assign row_end   = (WSW'(r_col) + WSW'(1)) >= w_eff;
    assign bottom    = (HSW'(r_row) + HSW'(1)) >= h_eff;
    assign frame_end = row_end && bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= 1'b0;
            r_s1_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
                if (frame_end) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_left <= 1'b0;
                end else if (row_end) begin
                    r_col  <= '0;
                    r_row  <= r_row + YW'(1);
                    r_left <= 1'b0;
                end else begin
                    r_col  <= r_col + XW'(1);
                    r_left <= pix_fg;
                end
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x         <= r_col;
            r_s1_y         <= r_row;
            r_s1_fg        <= pix_fg;
            r_s1_left      <= (r_col != '0) && r_left;
            r_s1_top_row   <= r_row == '0;
            r_s1_row_end   <= row_end;
            r_s1_bottom    <= bottom;
            r_s1_frame_end <= frame_end;
            // The pixel leaving the read stage writes this very column now.
            r_s1_fwd       <= s1_adv && (r_s1_x == r_col);
            r_s1_fwd_val   <= r_s1_fg;
        end
    end

    // Row flag memory: written as a pixel leaves the read stage.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_flags[r_s1_x] <= r_s1_fg;
        end
        if (in_acc) begin
            r_rd <= r_flags[r_col];
        end
    end

    // ------------------------------------------------------------------
    // Edge decision and budget
    // ------------------------------------------------------------------
    always_comb begin
        above = !r_s1_top_row && (r_s1_fwd ? r_s1_fwd_val : r_rd);
        cand[mbee_pkg::SLOT_TOP]    = r_s1_fg ^ above;
        cand[mbee_pkg::SLOT_LEFT]   = r_s1_fg ^ r_s1_left;
        cand[mbee_pkg::SLOT_RIGHT]  = r_s1_fg && r_s1_row_end;
        cand[mbee_pkg::SLOT_BOTTOM] = r_s1_fg && r_s1_bottom;

        diff = {1'b0, r_edge_budget} - {1'b0, r_edge_cnt};
        if (diff[BW]) begin
            avail_cap = 3'd0;
        end else if (diff[BW-1:0] >= BW'(mbee_pkg::NUM_EDGES)) begin
            avail_cap = 3'(mbee_pkg::NUM_EDGES);
        end else begin
            avail_cap = diff[2:0];
        end

        // Edges are granted in emission order until the budget runs out.
        taken = 3'd0;
        pass  = '0;
        for (int i = 0; i < mbee_pkg::NUM_EDGES; i++) begin
            if (cand[i] && !r_budget_hit && (taken < avail_cap)) begin
                pass[i] = 1'b1;
                taken   = taken + 3'd1;
            end
        end

        hit_new = r_budget_hit || ((cand & ~pass) != '0);
        cnt_new = r_edge_cnt + BW'(taken);
        if (hit_new) begin
            status_new = mbee_pkg::STATUS_BUDGET;
        end else if (cnt_new == '0) begin
            status_new = mbee_pkg::STATUS_NO_FG;
        end else begin
            status_new = mbee_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt   <= '0;
            r_budget_hit <= 1'b0;
        end else if (s1_adv) begin
            if (r_s1_frame_end) begin
                r_edge_cnt   <= '0;
                r_budget_hit <= 1'b0;
            end else begin
                r_edge_cnt   <= cnt_new;
                r_budget_hit <= hit_new;
            end
        end
    end

    // ------------------------------------------------------------------
    // Emitter: one result per cycle, unless the receiver stalls it, into the output register
    // ------------------------------------------------------------------
    assign out_free  = !r_out_vld || i_ready;
    assign emit      = (r_pend != '0) && out_free;
    assign pend_low  = r_pend & (~r_pend + mbee_pkg::NUM_SLOTS'(1));
    assign pend_rest = r_pend & ~pend_low;
    assign s2_free   = (r_pend == '0) || (emit && (pend_rest == '0));
    assign s1_adv    = r_s1_vld && s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (s1_adv) begin
            r_pend <= {r_s1_frame_end, pass};
        end else if (emit) begin
            r_pend <= pend_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_ctx.x      <= CW'(r_s1_x);
            r_ctx.y      <= CW'(r_s1_y);
            r_ctx.fg     <= r_s1_fg;
            r_ctx.status <= status_new;
        end
    end

    always_comb begin
        x0       = r_ctx.x;
        x1       = r_ctx.x + CW'(1);
        y0       = r_ctx.y;
        y1       = r_ctx.y + CW'(1);
        n_kind   = mbee_pkg::KIND_EDGE;
        n_status = mbee_pkg::STATUS_OK;
        n_sx     = '0;
        n_sy     = '0;
        n_ex     = '0;
        n_ey     = '0;
        if (pend_low[mbee_pkg::SLOT_TOP]) begin
            n_sx = r_ctx.fg ? x0 : x1;
            n_sy = y0;
            n_ex = r_ctx.fg ? x1 : x0;
            n_ey = y0;
        end else if (pend_low[mbee_pkg::SLOT_LEFT]) begin
            n_sx = x0;
            n_sy = r_ctx.fg ? y1 : y0;
            n_ex = x0;
            n_ey = r_ctx.fg ? y0 : y1;
        end else if (pend_low[mbee_pkg::SLOT_RIGHT]) begin
            n_sx = x1;
            n_sy = y0;
            n_ex = x1;
            n_ey = y1;
        end else if (pend_low[mbee_pkg::SLOT_BOTTOM]) begin
            n_sx = x1;
            n_sy = y1;
            n_ex = x0;
            n_ey = y1;
        end else if (pend_low[mbee_pkg::SLOT_DONE]) begin
            n_kind   = mbee_pkg::KIND_DONE;
            n_status = r_ctx.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind   <= n_kind;
            r_out_sx     <= n_sx;
            r_out_sy     <= n_sy;
            r_out_ex     <= n_ex;
            r_out_ey     <= n_ey;
            r_out_status <= n_status;
            r_out_last   <= pend_rest == '0;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_kind         = r_out_kind;
    assign o_start_x      = r_out_sx;
    assign o_start_y      = r_out_sy;
    assign o_end_x        = r_out_ex;
    assign o_end_y        = r_out_ey;
    assign o_frame_status = r_out_status;
    assign o_last         = r_out_last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `MBEE_ASSERT_IMPL(a_done_is_last, o_valid && (o_kind == mbee_pkg::KIND_DONE), o_last, "frame-done result not marked last")
    `MBEE_ASSERT_IMPL(a_edge_status_zero, o_valid && (o_kind == mbee_pkg::KIND_EDGE), o_frame_status == mbee_pkg::STATUS_OK, "edge result carries a status")
    `MBEE_ASSERT_NEXT(a_s1_held, r_s1_vld && !s2_free, r_s1_vld && $stable(r_s1_x), "read stage lost a pixel while the emitter was busy")

endmodule

### tb/mask_boundary_edge_extractor_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mask boundary edge extractor: unit test
// Streams coverage bytes into the block and checks every crack edge and
// frame-done transaction against a cycle-free prediction of the same frame,
// across small frames, the size and threshold extremes, edge budgets,
// mid-frame size changes and several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module mask_boundary_edge_extractor_unit_test;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_PIXELS = 75;

    localparam int CW = mbee_pkg::COORD_W;
    localparam int DW = mbee_pkg::CFG_DATA_W;
    localparam int TW = mbee_pkg::THR_W;

    typedef struct packed {
        logic                          kind;
        logic [CW-1:0]                 start_x;
        logic [CW-1:0]                 start_y;
        logic [CW-1:0]                 end_x;
        logic [CW-1:0]                 end_y;
        logic [mbee_pkg::STATUS_W-1:0] frame_status;
        logic                          last;
    } t_edge_result;

    // Predicts the edges of each accepted pixel and holds them until the
    // block returns them.
    class crack_edge_scoreboard;
        logic [mbee_pkg::SIZE_W-1:0]   width_reg;
        logic [mbee_pkg::SIZE_W-1:0]   height_reg;
        logic [TW-1:0]                 thr_reg;
        logic [mbee_pkg::BUDGET_W-1:0] budget_reg;
        bit                            row_flags [mbee_pkg::DEF_MAX_WIDTH];
        bit                            left_fg;
        int unsigned                   col;
        int unsigned                   row;
        logic [mbee_pkg::BUDGET_W-1:0] emitted;
        bit                            budget_hit;
        t_edge_result                  expected_edges [$];
        t_edge_result                  pixel_edges [$];
        int                            errors;

        function new();
            width_reg  = mbee_pkg::RST_FRAME_WIDTH;
            height_reg = mbee_pkg::RST_FRAME_HEIGHT;
            thr_reg    = mbee_pkg::RST_FG_THRESHOLD;
            budget_reg = mbee_pkg::RST_EDGE_BUDGET;
            left_fg    = 1'b0;
            col        = 0;
            row        = 0;
            emitted    = '0;
            budget_hit = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(mbee_pkg::t_cfg_idx idx, logic [DW-1:0] data);
            case (idx)
                mbee_pkg::CFG_FRAME_WIDTH: begin
                    width_reg = data[mbee_pkg::SIZE_W-1:0];
                end
                mbee_pkg::CFG_FRAME_HEIGHT: begin
                    height_reg = data[mbee_pkg::SIZE_W-1:0];
                end
                mbee_pkg::CFG_FG_THRESHOLD: begin
                    thr_reg = data[TW-1:0];
                end
                mbee_pkg::CFG_EDGE_BUDGET: begin
                    budget_reg = data[mbee_pkg::BUDGET_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function int unsigned clamp_dim(logic [mbee_pkg::SIZE_W-1:0] v, int unsigned maxv);
            if (v == 0) return 1;
            if (32'(v) > maxv) return maxv;
            return 32'(v);
        endfunction

        function int unsigned eff_width();
            return clamp_dim(width_reg, mbee_pkg::DEF_MAX_WIDTH);
        endfunction

        function int unsigned eff_height();
            return clamp_dim(height_reg, mbee_pkg::DEF_MAX_HEIGHT);
        endfunction

        function bit frame_open();
            return (col != 0) || (row != 0);
        endfunction

        function int unsigned pending();
            return expected_edges.size();
        endfunction

        // Once the budget is spent, every further edge of the frame is lost.
        function void emit_edge(int unsigned sx, int unsigned sy,
                                int unsigned ex, int unsigned ey);
            t_edge_result r;
            if (budget_hit || emitted >= budget_reg) begin
                budget_hit = 1'b1;
                return;
            end
            emitted = emitted + 1'b1;
            r.kind         = mbee_pkg::KIND_EDGE;
            r.start_x      = CW'(sx);
            r.start_y      = CW'(sy);
            r.end_x        = CW'(ex);
            r.end_y        = CW'(ey);
            r.frame_status = mbee_pkg::STATUS_OK;
            r.last         = 1'b0;
            pixel_edges    = {pixel_edges, r};
        endfunction

        function void accept_pixel(logic [TW-1:0] cov);
            int unsigned  w;
            int unsigned  h;
            int unsigned  x;
            int unsigned  y;
            bit           fg;
            bit           above;
            bit           left;
            bit           row_end;
            bit           frame_end;
            t_edge_result done;
            w         = eff_width();
            h         = eff_height();
            x         = col;
            y         = row;
            fg        = (cov >= thr_reg);
            row_end   = (x + 1 >= w);
            frame_end = row_end && (y + 1 >= h);
            above     = (y != 0 && x < mbee_pkg::DEF_MAX_WIDTH) ? row_flags[x] : 1'b0;
            left      = (x != 0) && left_fg;
            pixel_edges.delete();

            if (fg && !above) emit_edge(x, y, x + 1, y);
            else if (!fg && above) emit_edge(x + 1, y, x, y);
            if (fg && !left) emit_edge(x, y + 1, x, y);
            else if (!fg && left) emit_edge(x, y, x, y + 1);
            if (fg && row_end) emit_edge(x + 1, y, x + 1, y + 1);
            if (fg && y + 1 >= h) emit_edge(x + 1, y + 1, x, y + 1);

            if (x < mbee_pkg::DEF_MAX_WIDTH) row_flags[x] = fg;
            left_fg = fg;

            if (frame_end) begin
                done      = '0;
                done.kind = mbee_pkg::KIND_DONE;
                if (budget_hit) done.frame_status = mbee_pkg::STATUS_BUDGET;
                else if (emitted == 0) done.frame_status = mbee_pkg::STATUS_NO_FG;
                else done.frame_status = mbee_pkg::STATUS_OK;
                pixel_edges = {pixel_edges, done};
                col        = 0;
                row        = 0;
                left_fg    = 1'b0;
                emitted    = '0;
                budget_hit = 1'b0;
            end else if (row_end) begin
                col     = 0;
                row     = y + 1;
                left_fg = 1'b0;
            end else begin
                col = x + 1;
            end

            if (pixel_edges.size() != 0) pixel_edges[pixel_edges.size() - 1].last = 1'b1;
            expected_edges = {expected_edges, pixel_edges};
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_result(t_edge_result got);
            t_edge_result want;
            if (expected_edges.size() == 0) begin
                errors++;
                $error("result with nothing expected: kind %0d (%0d,%0d)->(%0d,%0d)",
                       got.kind, got.start_x, got.start_y, got.end_x, got.end_y);
                return;
            end
            want = expected_edges.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("start_x", 32'(want.start_x), 32'(got.start_x));
            compare_field("start_y", 32'(want.start_y), 32'(got.start_y));
            compare_field("end_x", 32'(want.end_x), 32'(got.end_x));
            compare_field("end_y", 32'(want.end_y), 32'(got.end_y));
            compare_field("frame_status", 32'(want.frame_status), 32'(got.frame_status));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [mbee_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [DW-1:0]                   i_cfg_data;
    logic                            i_valid;
    logic                            o_ready;
    logic [TW-1:0]                   i_coverage;
    logic                            o_valid;
    logic                            i_ready;
    logic                            o_kind;
    logic [CW-1:0]                   o_start_x;
    logic [CW-1:0]                   o_start_y;
    logic [CW-1:0]                   o_end_x;
    logic [CW-1:0]                   o_end_y;
    logic [mbee_pkg::STATUS_W-1:0]   o_frame_status;
    logic                            o_last;

    crack_edge_scoreboard sb;
    int unsigned          send_idle_pct = 0;
    int unsigned          stall_pct = 0;
    int unsigned          pixels_sent = 0;
    int unsigned          cycle_count = 0;

    mask_boundary_edge_extractor_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_coverage     (i_coverage),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_start_x      (o_start_x),
        .o_start_y      (o_start_y),
        .o_end_x        (o_end_x),
        .o_end_y        (o_end_y),
        .o_frame_status (o_frame_status),
        .o_last         (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready = ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_edge_result seen;
        if (i_rst_n && o_valid && i_ready) begin
            seen.kind         = o_kind;
            seen.start_x      = o_start_x;
            seen.start_y      = o_start_y;
            seen.end_x        = o_end_x;
            seen.end_y        = o_end_y;
            seen.frame_status = o_frame_status;
            seen.last         = o_last;
            sb.check_result(seen);
        end
    end

    // Random bits above the register width, which the block must ignore.
    function automatic logic [DW-1:0] noisy(int unsigned val, int unsigned bits);
        logic [DW-1:0] r;
        r = DW'($urandom);
        for (int i = 0; i < bits; i++) r[i] = val[i];
        return r;
    endfunction

    function automatic logic [TW-1:0] pick_coverage(int unsigned fg_pct);
        int unsigned t;
        t = 32'(sb.thr_reg);
        if ($urandom_range(0, 9) == 0) return TW'($urandom_range(0, 255));
        if (t == 0 || $urandom_range(0, 99) < fg_pct) return TW'($urandom_range(t, 255));
        return TW'($urandom_range(0, t - 1));
    endfunction

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_pixel(input logic [TW-1:0] cov);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_coverage = cov;
        do @(posedge i_clk); while (!o_ready);
        sb.accept_pixel(cov);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // A pixel with no edges may still be in the pipeline when the last
    // expected transaction has gone, hence the settling cycles.
    task automatic drain_results();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input mbee_pkg::t_cfg_idx idx, input logic [DW-1:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_frame(input logic [DW-1:0] w, input logic [DW-1:0] h,
                             input logic [DW-1:0] thr,
                             input logic [DW-1:0] bud);
        drain_results();
        write_reg(mbee_pkg::CFG_FRAME_WIDTH, w);
        write_reg(mbee_pkg::CFG_FRAME_HEIGHT, h);
        write_reg(mbee_pkg::CFG_FG_THRESHOLD, thr);
        write_reg(mbee_pkg::CFG_EDGE_BUDGET, bud);
    endtask

    task automatic fill_frame(input int unsigned fg_pct);
        do send_pixel(pick_coverage(fg_pct)); while (sb.frame_open());
    endtask

    task automatic random_frame();
        int unsigned   w;
        int unsigned   h;
        int unsigned   k;
        int unsigned   fg_pct;
        logic [DW-1:0] bud;
        fg_pct = $urandom_range(0, 100);
        if ($urandom_range(0, 99) < 60) begin
            w = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
            h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
            case ($urandom_range(0, 3))
                0: bud = DW'($urandom_range(0, 12));
                1: bud = DW'($urandom);
                default: bud = mbee_pkg::RST_EDGE_BUDGET;
            endcase
            set_frame(noisy(w, mbee_pkg::SIZE_W), noisy(h, mbee_pkg::SIZE_W),
                      noisy($urandom_range(0, 255), TW), bud);
        end
        w = sb.eff_width();
        h = sb.eff_height();
        // Resize part-way through; the width only shrinks so that no row
        // reads a column flag that was never written.
        if (w * h > 1 && $urandom_range(0, 99) < 20) begin
            k = $urandom_range(1, w * h - 1);
            repeat (k) send_pixel(pick_coverage(fg_pct));
            drain_results();
            if ($urandom_range(0, 1) == 1 && w > 1)
                write_reg(mbee_pkg::CFG_FRAME_WIDTH,
                          noisy($urandom_range(1, w - 1), mbee_pkg::SIZE_W));
            else
                write_reg(mbee_pkg::CFG_FRAME_HEIGHT,
                          noisy($urandom_range(0, 6), mbee_pkg::SIZE_W));
        end
        fill_frame(fg_pct);
    endtask

    initial begin
        int unsigned phase_start;
        sb         = new();
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_addr = mbee_pkg::CFG_FRAME_WIDTH;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_coverage = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Threshold boundary and coverage extremes in a 3x2 frame.
        set_frame(3, 2, 128, mbee_pkg::RST_EDGE_BUDGET);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd127);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);

        // Zero sizes act as a single pixel: a foreground pixel with an edge on each side
        // and the done item, then a frame with no foreground.
        set_frame(0, 0, 128, mbee_pkg::RST_EDGE_BUDGET);
        send_pixel(8'd200);
        send_pixel(8'd10);

        // A zero budget drops every edge.
        set_frame(2, 1, 128, 0);
        send_pixel(8'd200);
        send_pixel(8'd255);

        // Budget runs out part-way; a zero threshold makes everything foreground.
        set_frame(2, 2, 0, 3);
        repeat (4) send_pixel(8'd0);

        set_frame(2, 1, 255, mbee_pkg::RST_EDGE_BUDGET);
        send_pixel(8'd254);
        send_pixel(8'd255);

        // Height cut while on the second row: the frame ends with that row.
        set_frame(3, 4, 128, mbee_pkg::RST_EDGE_BUDGET);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        drain_results();
        write_reg(mbee_pkg::CFG_FRAME_HEIGHT, 1);
        fill_frame(50);

        // Width cut with the column counter already past the new last column.
        set_frame(5, 2, 128, mbee_pkg::RST_EDGE_BUDGET);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        drain_results();
        write_reg(mbee_pkg::CFG_FRAME_WIDTH, 2);
        fill_frame(50);

        // Oversized sizes count as the maximum, so the row or frame runs on
        // until a later cut ends it at the current pixel.
        set_frame(8191, 1, 128, mbee_pkg::RST_EDGE_BUDGET);
        repeat (5) send_pixel(pick_coverage(50));
        drain_results();
        write_reg(mbee_pkg::CFG_FRAME_WIDTH, 6);
        fill_frame(50);
        set_frame(1, 8191, 128, mbee_pkg::RST_EDGE_BUDGET);
        repeat (4) send_pixel(pick_coverage(40));
        drain_results();
        write_reg(mbee_pkg::CFG_FRAME_HEIGHT, 2);
        fill_frame(40);

        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 70;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 70;
                end
                default: begin
                    send_idle_pct = 28;
                    stall_pct     = 28;
                end
            endcase
            phase_start = pixels_sent;
            while (pixels_sent - phase_start < PHASE_PIXELS) random_frame();
        end

        drain_results();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
